// ===== rtl/core/tssm_pkg.sv =====
// ----------------------------------------------------------------------------
// Throttle/speed step map package
// Shared widths, band limits, direction codes and register indexes.
// ----------------------------------------------------------------------------
package tssm_pkg;

    localparam int CFG_W   = 15;
    localparam int STEP_W  = 16;
    localparam int SPEED_W = 16;
    localparam int THR_W   = 15;
    localparam int DIR_W   = 2;

    // Throttle band: 0.1 and 0.9 in Q15, and the width of the band.
    localparam logic [THR_W-1:0] THR_LOW  = 15'd3277;
    localparam logic [THR_W-1:0] THR_HIGH = 15'd29491;
    localparam logic [CFG_W-1:0] THR_SPAN = 15'd26214;
    localparam int               QBITS    = 15;

    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD = 2'd2;

    localparam logic [2:0] REG_LOW_SPEED  = 3'd0;
    localparam logic [2:0] REG_HIGH_SPEED = 3'd1;
    localparam logic [2:0] REG_LOW_STEP   = 3'd2;
    localparam logic [2:0] REG_HIGH_STEP  = 3'd3;
    localparam logic [2:0] REG_IDLE_STEP  = 3'd4;

endpackage

// ===== rtl/core/throttle_speed_step_map_core.sv =====
// ----------------------------------------------------------------------------
// Throttle/speed step map core
// Turns gear direction, signed speed and Q15 throttle into a drive step size.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ channel with direction, speed and throttle;
//   each yields one result item on the m_ channel: the saturated step in
//   m_tdata and, in m_tuser, a flag set when the step was newly computed and
//   clear when the previous step was held. The five map registers are to be
//   written through the APB port only while no item is in flight, which the
//   core itself does not enforce; they clear at reset, as does the held step.
//   An item that holds the step goes straight to the output stage; one whose
//   speed and throttle both miss their interpolation bands passes through the
//   throttle banding state first. Interpolation runs on serial dividers (one
//   quotient bit per cycle) and shift-and-add multipliers: two multiplies and
//   a division for the speed line, a division and a multiply for the throttle.
//   s_tready is high only while the sequencer is idle. A finished result sits
//   in the output register, so the next item is accepted while it waits; if
//   the receiver still stalls when that next result is done, the sequencer
//   waits until the output frees up. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module throttle_speed_step_map_core
    import tssm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] direction, [17:2] speed, [32:18] throttle
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] step_out
    output logic [0:0]  m_tuser,   // [0] updated
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;  // waiting for an item
    localparam logic [3:0] ST_MUL0  = 4'd1;  // offset numerator ls*hi - hs*lo
    localparam logic [3:0] ST_DLOAD = 4'd2;  // set up slope and offset division
    localparam logic [3:0] ST_DIV   = 4'd3;  // serial division, one bit a cycle
    localparam logic [3:0] ST_MUL   = 4'd4;  // serial multiply, one bit a cycle
    localparam logic [3:0] ST_FLOOR = 4'd5;  // Q15 shift rounding toward -inf
    localparam logic [3:0] ST_ADD   = 4'd6;  // add offset or idle step, saturate
    localparam logic [3:0] ST_THR   = 4'd7;  // throttle banding
    localparam logic [3:0] ST_FIN   = 4'd8;  // hand the result to the output

    // Configuration registers.
    logic [CFG_W-1:0] low_speed_reg, high_speed_reg;
    logic [CFG_W-1:0] low_step_reg, high_step_reg, idle_step_reg;

    // Control state.
    logic [3:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        phase2_reg, phase2_next;  // clear: speed map, set: throttle map
    logic        m_tvalid_reg, m_tvalid_next;
    logic signed [STEP_W-1:0] held_step_reg, held_step_next;

    // Datapath.
    logic [SPEED_W-1:0] s_mag_reg, s_mag_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic               upd_reg, upd_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [15:0]        mplr_reg, mplr_next;
    logic [15:0]        lo_sh_reg, lo_sh_next;
    logic signed [45:0] prod_reg, prod_next;
    logic               prod_neg_reg, prod_neg_next;
    logic               off_neg_reg, off_neg_next;
    logic [30:0]        num_a_reg, num_a_next;
    logic [30:0]        num_b_reg, num_b_next;
    logic [14:0]        rem_a_reg, rem_a_next;
    logic [14:0]        rem_b_reg, rem_b_next;
    logic [CFG_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]  out_step_reg, out_step_next;
    logic               out_upd_reg, out_upd_next;

    // Input item fields.
    logic [DIR_W-1:0]          in_dir;
    logic signed [SPEED_W-1:0] in_speed;
    logic [THR_W-1:0]          in_thr;
    logic                      in_ok;
    logic [SPEED_W-1:0]        in_s_mag;

    assign in_dir   = s_tdata[1:0];
    assign in_speed = s_tdata[17:2];
    assign in_thr   = s_tdata[32:18];

    // The speed must not point against the gear; neutral always holds.
    assign in_ok = ((in_dir == DIR_FWD) && !in_speed[SPEED_W-1]) ||
                   ((in_dir == DIR_BWD) && (in_speed[SPEED_W-1] || (in_speed == '0)));
    assign in_s_mag = (in_dir == DIR_FWD) ? in_speed : (~in_speed + 16'd1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_step_reg;
    assign m_tuser  = out_upd_reg;
    assign pready   = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_speed_reg  <= '0;
            high_speed_reg <= '0;
            low_step_reg   <= '0;
            high_step_reg  <= '0;
            idle_step_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_LOW_SPEED:  low_speed_reg  <= pwdata[CFG_W-1:0];
                REG_HIGH_SPEED: high_speed_reg <= pwdata[CFG_W-1:0];
                REG_LOW_STEP:   low_step_reg   <= pwdata[CFG_W-1:0];
                REG_HIGH_STEP:  high_step_reg  <= pwdata[CFG_W-1:0];
                REG_IDLE_STEP:  idle_step_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LOW_SPEED:  prdata = {17'd0, low_speed_reg};
            REG_HIGH_SPEED: prdata = {17'd0, high_speed_reg};
            REG_LOW_STEP:   prdata = {17'd0, low_step_reg};
            REG_HIGH_STEP:  prdata = {17'd0, high_step_reg};
            REG_IDLE_STEP:  prdata = {17'd0, idle_step_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Shared arithmetic.
    // ------------------------------------------------------------------------
    // Divider lanes: restoring division, one quotient bit shifted in per cycle
    // while the numerator shifts out at the top. Lane B only matters for the
    // speed map, where it produces the offset.
    logic [15:0] rtry_a, rtry_b;
    logic        ge_a, ge_b;
    logic [15:0] rdif_a, rdif_b;

    assign rtry_a = {rem_a_reg, num_a_reg[30]};
    assign rtry_b = {rem_b_reg, num_b_reg[30]};
    assign ge_a   = rtry_a >= {1'b0, div_reg};
    assign ge_b   = rtry_b >= {1'b0, div_reg};
    assign rdif_a = rtry_a - {1'b0, div_reg};
    assign rdif_b = rtry_b - {1'b0, div_reg};

    // Multiply-accumulate, multiplier bits taken from the top (Horner form).
    logic signed [45:0] prod_dbl, mul0_term, mul_term;

    assign prod_dbl  = {prod_reg[44:0], 1'b0};
    assign mul0_term = (mplr_reg[15]  ? $signed({31'd0, low_step_reg})  : 46'sd0) -
                       (lo_sh_reg[15] ? $signed({31'd0, high_step_reg}) : 46'sd0);
    assign mul_term  = mplr_reg[15] ? $signed({15'd0, num_a_reg}) : 46'sd0;

    // Q15 shift of a sign-magnitude product, rounding toward minus infinity.
    logic [46:0] pm_bias;
    logic [31:0] fl_mag;

    assign pm_bias = {1'b0, prod_reg} + 47'd32767;
    assign fl_mag  = prod_neg_reg ? pm_bias[46:QBITS] : {1'b0, prod_reg[45:QBITS]};

    // Final add and 16-bit saturation.
    logic signed [33:0] addend, sum;
    logic signed [STEP_W-1:0] sum_sat;

    always_comb begin
        if (phase2_reg) begin
            addend = $signed({19'd0, idle_step_reg});
        end else if (off_neg_reg) begin
            addend = -$signed({3'd0, num_b_reg});
        end else begin
            addend = $signed({3'd0, num_b_reg});
        end
        sum = prod_reg[33:0] + addend;
        if (sum > 34'sd32767) begin
            sum_sat = 16'sh7fff;
        end else if (sum < -34'sd32768) begin
            sum_sat = -16'sh8000;
        end else begin
            sum_sat = sum[STEP_W-1:0];
        end
    end

    // Throttle band: distance from the full step down to the idle step.
    logic signed [16:0] thr_diff;
    logic [15:0]        thr_diff_mag;

    assign thr_diff     = {step_reg[STEP_W-1], step_reg} - $signed({2'd0, idle_step_reg});
    assign thr_diff_mag = thr_diff[16] ? 16'(-thr_diff) : thr_diff[15:0];

    // Speed map: magnitude of the step difference and of the offset numerator.
    logic [CFG_W-1:0] step_dmag;
    logic [45:0]      prod_abs;

    assign step_dmag = (high_step_reg < low_step_reg) ? (low_step_reg - high_step_reg)
                                                      : (high_step_reg - low_step_reg);
    assign prod_abs  = prod_reg[45] ? 46'(-prod_reg) : prod_reg;

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase2_next    = phase2_reg;
        m_tvalid_next  = m_tvalid_reg;
        held_step_next = held_step_reg;
        s_mag_next     = s_mag_reg;
        thr_next       = thr_reg;
        upd_next       = upd_reg;
        step_next      = step_reg;
        mplr_next      = mplr_reg;
        lo_sh_next     = lo_sh_reg;
        prod_next      = prod_reg;
        prod_neg_next  = prod_neg_reg;
        off_neg_next   = off_neg_reg;
        num_a_next     = num_a_reg;
        num_b_next     = num_b_reg;
        rem_a_next     = rem_a_reg;
        rem_b_next     = rem_b_reg;
        div_next       = div_reg;
        out_step_next  = out_step_reg;
        out_upd_next   = out_upd_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    s_mag_next  = in_s_mag;
                    thr_next    = in_thr;
                    upd_next    = in_ok;
                    phase2_next = 1'b0;
                    if (!in_ok) begin
                        step_next  = held_step_reg;
                        state_next = ST_FIN;
                    end else if (in_s_mag < {1'b0, low_speed_reg}) begin
                        step_next  = $signed({1'b0, low_step_reg});
                        state_next = ST_THR;
                    end else if (in_s_mag > {1'b0, high_speed_reg}) begin
                        step_next  = $signed({1'b0, high_step_reg});
                        state_next = ST_THR;
                    end else if (high_speed_reg == low_speed_reg) begin
                        // Equal bounds: no line to follow.
                        step_next  = $signed({1'b0, low_step_reg});
                        state_next = ST_THR;
                    end else begin
                        prod_next  = '0;
                        mplr_next  = {1'b0, high_speed_reg};
                        lo_sh_next = {1'b0, low_speed_reg};
                        cnt_next   = 5'd15;
                        state_next = ST_MUL0;
                    end
                end
            end

            ST_MUL0: begin
                prod_next  = prod_dbl + mul0_term;
                mplr_next  = {mplr_reg[14:0], 1'b0};
                lo_sh_next = {lo_sh_reg[14:0], 1'b0};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_DLOAD;
                end
            end

            ST_DLOAD: begin
                num_a_next    = {1'b0, step_dmag, 15'd0};
                num_b_next    = prod_abs[30:0];
                off_neg_next  = prod_reg[45];
                prod_neg_next = high_step_reg < low_step_reg;
                div_next      = high_speed_reg - low_speed_reg;
                rem_a_next    = '0;
                rem_b_next    = '0;
                cnt_next      = 5'd30;
                state_next    = ST_DIV;
            end

            ST_DIV: begin
                rem_a_next = ge_a ? rdif_a[14:0] : rtry_a[14:0];
                rem_b_next = ge_b ? rdif_b[14:0] : rtry_b[14:0];
                num_a_next = {num_a_reg[29:0], ge_a};
                num_b_next = {num_b_reg[29:0], ge_b};
                cnt_next   = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    prod_next  = '0;
                    mplr_next  = phase2_reg ? {1'b0, thr_reg - THR_LOW} : s_mag_reg;
                    cnt_next   = 5'd15;
                    state_next = ST_MUL;
                end
            end

            ST_MUL: begin
                prod_next = prod_dbl + mul_term;
                mplr_next = {mplr_reg[14:0], 1'b0};
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_FLOOR;
                end
            end

            ST_FLOOR: begin
                prod_next  = prod_neg_reg ? -$signed({14'd0, fl_mag})
                                          :  $signed({14'd0, fl_mag});
                state_next = ST_ADD;
            end

            ST_ADD: begin
                step_next  = sum_sat;
                state_next = phase2_reg ? ST_FIN : ST_THR;
            end

            ST_THR: begin
                // step_reg holds the full-throttle step here.
                if (thr_reg < THR_LOW) begin
                    step_next  = $signed({1'b0, idle_step_reg});
                    state_next = ST_FIN;
                end else if (thr_reg > THR_HIGH) begin
                    state_next = ST_FIN;
                end else begin
                    phase2_next   = 1'b1;
                    num_a_next    = {thr_diff_mag, 15'd0};
                    num_b_next    = '0;
                    prod_neg_next = thr_diff[16];
                    div_next      = THR_SPAN;
                    rem_a_next    = '0;
                    rem_b_next    = '0;
                    cnt_next      = 5'd30;
                    state_next    = ST_DIV;
                end
            end

            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_step_next  = step_reg;
                    out_upd_next   = upd_reg;
                    m_tvalid_next  = 1'b1;
                    held_step_next = step_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase2_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            held_step_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase2_reg    <= phase2_next;
            m_tvalid_reg  <= m_tvalid_next;
            held_step_reg <= held_step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        s_mag_reg    <= s_mag_next;
        thr_reg      <= thr_next;
        upd_reg      <= upd_next;
        step_reg     <= step_next;
        mplr_reg     <= mplr_next;
        lo_sh_reg    <= lo_sh_next;
        prod_reg     <= prod_next;
        prod_neg_reg <= prod_neg_next;
        off_neg_reg  <= off_neg_next;
        num_a_reg    <= num_a_next;
        num_b_reg    <= num_b_next;
        rem_a_reg    <= rem_a_next;
        rem_b_reg    <= rem_b_next;
        div_reg      <= div_next;
        out_step_reg <= out_step_next;
        out_upd_reg  <= out_upd_next;
    end

endmodule

// ===== dv/throttle_speed_step_map_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Throttle/speed step map core testbench
// Drives direction/speed/throttle items into the core under several map
// settings, predicts every step in the testbench and checks each result item
// in order. Both stream sides idle at random. The receiver also holds off
// once for a long stretch so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module throttle_speed_step_map_core_tb;
    import tssm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int GAP_MAX         = 13;
    localparam int HOLD_OFF_CYCLES = 300;
    // Drain time after the last phase, with margin over the slowest item.
    localparam int DRAIN_CYCLES    = 150;
    localparam int PHASE_ITEMS     = 85;
    localparam int NUM_PHASES      = 12;
    localparam int REPORT_MAX      = 10;
    localparam int TIMEOUT_NS      = 8_000_000;
    localparam int NUM_ROWS        = 17;

    // Direction codes that select neither gear.
    localparam logic [DIR_W-1:0] DIR_NEUTRAL = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SPARE   = 2'd3;

    // Register indexes past the end of the map; writes to them are dropped.
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam longint Q_ONE = longint'(1) << QBITS;

    typedef struct {
        logic signed [STEP_W-1:0] step;
        logic                     updated;
    } step_item_t;

    typedef struct {
        logic [DIR_W-1:0]          dir;
        logic signed [SPEED_W-1:0] speed;
        logic [THR_W-1:0]          thr;
        bit                        typed;
        logic signed [STEP_W-1:0]  step;
        logic                      updated;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [1:0] direction, [17:2] speed, [32:18] throttle
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] step_out
    logic [0:0]  m_tuser;         // [0] updated
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Testbench copy of the map registers and of the held step.
    logic [CFG_W-1:0]         map_low_speed  = '0;
    logic [CFG_W-1:0]         map_high_speed = '0;
    logic [CFG_W-1:0]         map_low_step   = '0;
    logic [CFG_W-1:0]         map_high_step  = '0;
    logic [CFG_W-1:0]         map_idle_step  = '0;
    logic signed [STEP_W-1:0] held_step_q    = '0;

    step_item_t pending_steps[$];
    int         mismatch_count = 0;

    // Idling controls shared between the stimulus and the result sink.
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    bit hold_off_req = 1'b0;

    throttle_speed_step_map_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Step prediction
    // ------------------------------------------------------------------------

    function automatic longint clamp_step(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Full-throttle step as a function of speed magnitude. Between the two
    // speed bounds the step lies on a Q15 line: the slope and the offset use
    // truncating division, the product with the speed is floored.
    function automatic longint full_throttle_step(longint mag);
        longint lo, hi, ls, hs, span, slope, offset;
        lo = map_low_speed;
        hi = map_high_speed;
        ls = map_low_step;
        hs = map_high_step;
        if (mag < lo) return ls;
        if (mag > hi) return hs;
        // Equal bounds leave no line to follow; take the low-speed step.
        span = hi - lo;
        if (span <= 0) return ls;
        slope  = ((hs - ls) * Q_ONE) / span;
        offset = (ls * hi - hs * lo) / span;
        return ((slope * mag) >>> QBITS) + offset;
    endfunction

    // Works out the result of one item and advances the held step.
    function automatic step_item_t predict_step(logic [DIR_W-1:0] dir,
                                                logic signed [SPEED_W-1:0] speed,
                                                logic [THR_W-1:0] thr);
        longint     spd, mag, t, idle, full, res, k, t_lo, t_hi, t_span;
        bit         drive;
        step_item_t r;
        spd    = speed;
        t      = thr;
        idle   = map_idle_step;
        t_lo   = THR_LOW;
        t_hi   = THR_HIGH;
        t_span = THR_SPAN;
        drive  = 1'b0;
        mag    = 0;
        if (dir == DIR_FWD) begin
            drive = (spd >= 0);
            mag   = spd;
        end else if (dir == DIR_BWD) begin
            drive = (spd <= 0);
            mag   = -spd;
        end
        // Neutral, or speed against the gear: the previous step is held.
        if (!drive) begin
            r.step    = held_step_q;
            r.updated = 1'b0;
            return r;
        end
        full = clamp_step(full_throttle_step(mag));
        if (t < t_lo) begin
            res = idle;
        end else if (t > t_hi) begin
            res = full;
        end else begin
            k   = ((full - idle) * Q_ONE) / t_span;
            res = ((k * (t - t_lo)) >>> QBITS) + idle;
        end
        res         = clamp_step(res);
        held_step_q = res[STEP_W-1:0];
        r.step      = held_step_q;
        r.updated   = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // A setup phase followed by an access phase; the caller sits just after an edge.
    task automatic apb_access(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The upper bits of the write data are junk: only the low 15 bits count.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom;
        apb_access(idx, 1'b1, {junk[31:CFG_W], val}, rd);
        case (idx)
            REG_LOW_SPEED:  map_low_speed  = val;
            REG_HIGH_SPEED: map_high_speed = val;
            REG_LOW_STEP:   map_low_step   = val;
            REG_HIGH_STEP:  map_high_step  = val;
            REG_IDLE_STEP:  map_idle_step  = val;
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [2:0] idx, input logic [CFG_W-1:0] want);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== want)
            report_mismatch("register readback", want, rd[CFG_W-1:0]);
    endtask

    task automatic program_map(input logic [CFG_W-1:0] lo, hi, ls, hs, idle);
        write_reg(REG_LOW_SPEED, lo);
        write_reg(REG_HIGH_SPEED, hi);
        write_reg(REG_LOW_STEP, ls);
        write_reg(REG_HIGH_STEP, hs);
        write_reg(REG_IDLE_STEP, idle);
        check_reg(REG_LOW_SPEED, map_low_speed);
        check_reg(REG_HIGH_SPEED, map_high_speed);
        check_reg(REG_LOW_STEP, map_low_step);
        check_reg(REG_HIGH_STEP, map_high_step);
        check_reg(REG_IDLE_STEP, map_idle_step);
    endtask

    // ------------------------------------------------------------------------
    // Input stream
    // ------------------------------------------------------------------------

    // Offers one item after an optional gap and waits for it to be taken.
    // The valid is only lowered when a gap follows, so back-to-back items
    // never see the valid dropped and raised within one edge.
    task automatic send_item(input logic [DIR_W-1:0] dir,
                             input logic signed [SPEED_W-1:0] speed,
                             input logic [THR_W-1:0] thr,
                             input bit typed, input step_item_t typed_step);
        int         gap;
        step_item_t pred;
        gap = tx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, thr, speed, dir};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The predictor always runs so that the held step stays in step.
        pred = predict_step(dir, speed, thr);
        pending_steps.push_back(typed ? typed_step : pred);
    endtask

    // Mostly well-formed items: speed with the sign of the gear, often in
    // the interpolation band or on its edges, throttle mostly in its band.
    // A minority is neutral, wrong-signed or raw noise.
    task automatic send_random_item();
        int                        mag, lo, hi;
        logic [DIR_W-1:0]          dir;
        logic signed [SPEED_W-1:0] speed;
        logic [THR_W-1:0]          thr;
        step_item_t                unused;
        lo = map_low_speed;
        hi = map_high_speed;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: mag = $urandom_range(lo, hi);
            4: begin
                case ($urandom_range(0, 3))
                    0: mag = lo;
                    1: mag = hi;
                    2: mag = lo - 1;
                    default: mag = hi + 1;
                endcase
            end
            default: mag = $urandom_range(0, 32767);
        endcase
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        dir   = ($urandom_range(0, 1) != 0) ? DIR_FWD : DIR_BWD;
        speed = (dir == DIR_FWD) ? SPEED_W'(mag) : -SPEED_W'(mag);
        case ($urandom_range(0, 19))
            0: dir = ($urandom_range(0, 1) != 0) ? DIR_NEUTRAL : DIR_SPARE;
            1: speed = -speed;
            2: begin
                dir   = DIR_W'($urandom);
                speed = SPEED_W'($urandom);
            end
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: thr = THR_W'($urandom_range(THR_LOW, THR_HIGH));
            6, 7: thr = THR_W'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0: thr = '0;
                    1: thr = THR_LOW - 15'd1;
                    2: thr = THR_LOW;
                    3: thr = THR_HIGH;
                    4: thr = THR_HIGH + 15'd1;
                    default: thr = '1;
                endcase
            end
        endcase
        unused = '{default: '0};
        send_item(dir, speed, thr, 1'b0, unused);
    endtask

    // Drops the valid and waits until every result of the phase has arrived,
    // so that the map can be rewritten while the core is idle.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    // Each result waits out a random stall, or the long hold-off once it has
    // been asked for; the hold-off is counted here, in cycles.
    initial begin : result_sink
        int         wait_cycles;
        step_item_t want;
        bit         hold_off_done;
        hold_off_done = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            wait_cycles = rx_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
            if (hold_off_req && !hold_off_done) begin
                wait_cycles   = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_steps.size() == 0) begin
                report_mismatch("result item with nothing expected, step_out",
                                0, $signed(m_tdata));
            end else begin
                want = pending_steps.pop_front();
                if (m_tdata !== want.step)
                    report_mismatch("step_out", want.step, $signed(m_tdata));
                if (m_tuser[0] !== want.updated)
                    report_mismatch("updated", want.updated, m_tuser[0]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t  directed_rows [NUM_ROWS];
        step_item_t row_step;
        int         lo, hi;

        // The directed rows run with low_speed 1000, high_speed 20000,
        // steps 500 and 30000, and idle step 100. Rows with a typed result
        // are those that can be read straight off the map; the rest go
        // through the predictor.
        directed_rows = '{
            // Neutral right after reset returns the cleared held step.
            '{DIR_NEUTRAL, 16'sd5000,   15'd20000, 1'b1, 16'sd0,     1'b0},
            // Throttle below the band gives the idle step.
            '{DIR_FWD,     16'sd0,      15'd0,     1'b1, 16'sd100,   1'b1},
            // Top speed and full pedal give the high-speed step.
            '{DIR_FWD,     16'sd32767,  15'd32767, 1'b1, 16'sd30000, 1'b1},
            // Most negative speed in reverse is the largest magnitude.
            '{DIR_BWD,     16'sh8000,   15'd32767, 1'b1, 16'sd30000, 1'b1},
            // Speed against the gear, both ways, and the spare code: held.
            '{DIR_BWD,     16'sd1,      15'd16000, 1'b1, 16'sd30000, 1'b0},
            '{DIR_FWD,     -16'sd1,     15'd16000, 1'b1, 16'sd30000, 1'b0},
            '{DIR_SPARE,   16'sd0,      15'd16000, 1'b1, 16'sd30000, 1'b0},
            // Below the low speed at full pedal: the low-speed step.
            '{DIR_FWD,     16'sd500,    15'd32767, 1'b1, 16'sd500,   1'b1},
            // Just above the high speed at full pedal.
            '{DIR_FWD,     16'sd20001,  15'd29492, 1'b1, 16'sd30000, 1'b1},
            // Just under the throttle band.
            '{DIR_FWD,     16'sd10000,  15'd3276,  1'b1, 16'sd100,   1'b1},
            // Band edges for speed and throttle go through the predictor.
            '{DIR_FWD,     16'sd1000,   15'd29492, 1'b0, 16'sd0,     1'b0},
            '{DIR_FWD,     16'sd20000,  15'd29491, 1'b0, 16'sd0,     1'b0},
            '{DIR_FWD,     16'sd10000,  15'd3277,  1'b0, 16'sd0,     1'b0},
            '{DIR_BWD,     -16'sd10000, 15'd16000, 1'b0, 16'sd0,     1'b0},
            '{DIR_BWD,     16'sd0,      15'd16000, 1'b0, 16'sd0,     1'b0},
            '{DIR_FWD,     16'sd0,      15'd16000, 1'b0, 16'sd0,     1'b0},
            '{DIR_NEUTRAL, 16'sh8000,   15'd0,     1'b0, 16'sd0,     1'b0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Writes past the end of the map must leave the real registers
        // alone; program_map then rewrites all five and reads them back.
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        program_map(15'd1000, 15'd20000, 15'd500, 15'd30000, 15'd100);

        foreach (directed_rows[i]) begin
            row_step.step    = directed_rows[i].step;
            row_step.updated = directed_rows[i].updated;
            send_item(directed_rows[i].dir, directed_rows[i].speed, directed_rows[i].thr,
                      directed_rows[i].typed, row_step);
        end
        finish_phase();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                // All registers at zero.
                0: program_map('0, '0, '0, '0, '0);
                // All registers at full scale; the bounds are equal.
                1: program_map('1, '1, '1, '1, '1);
                // Widest speed band, idle step above the full step.
                2: program_map('0, '1, '0, '1, '1);
                // Falling full step across the band.
                3: program_map('0, '1, '1, '0, '0);
                // Equal speed bounds somewhere in the middle.
                4: begin
                    lo = $urandom_range(1000, 30000);
                    program_map(CFG_W'(lo), CFG_W'(lo), CFG_W'($urandom),
                                CFG_W'($urandom), CFG_W'($urandom));
                end
                // High bound below the low bound: the band is empty.
                5: program_map(15'd20000, 15'd100, CFG_W'($urandom),
                               CFG_W'($urandom), CFG_W'($urandom));
                default: begin
                    lo = $urandom_range(0, 16000);
                    hi = $urandom_range(lo, 32767);
                    program_map(CFG_W'(lo), CFG_W'(hi), CFG_W'($urandom),
                                CFG_W'($urandom), CFG_W'($urandom));
                end
            endcase
            // Mix of idling patterns, with three phases where neither side idles.
            tx_gaps_on   = (p % 4 != 0) && (p % 4 != 3);
            rx_stalls_on = (p % 4 != 1) && (p % 4 != 3);
            if (p == 0) tx_gaps_on = 1'b0;
            // Long receiver hold-off while the sender keeps offering items.
            if (p == 6) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_steps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
